@@ src/snu_pkg.sv @@
// Shared constants, types and the CORDIC angle table for the sphere normal to UV block.
// Used by every module of the block; depends on nothing.
`default_nettype none
package snu_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int ANG_TABLE_LEN = 24;
  localparam int CORDIC_N = (CORDIC_STAGES < ANG_TABLE_LEN) ? CORDIC_STAGES : ANG_TABLE_LEN;

  // Datapath width of the CORDIC vector and of the angle accumulator.
  localparam int DW = 35;
  localparam int AW = 34;

  // Square root of a 61-bit radicand, one result bit per stage.
  localparam int SQ_ITER = 31;
  localparam int SQ_NW   = 61;
  localparam int SQ_RW   = 62;
  localparam int SQ_OW   = 31;

  // Input register, radicand register, root, CORDIC with its two end stages, output register.
  localparam int PIPE_LAT = 5 + SQ_ITER + CORDIC_N;

  typedef logic signed [DW-1:0] cvec_t;
  typedef logic signed [AW-1:0] ang_t;

  localparam ang_t ANG_HALF    = 34'sh0_8000_0000;
  localparam ang_t ANG_QUARTER = 34'sh0_4000_0000;

  // atan(2^-i) in units of 2^-32 turn.
  localparam logic [31:0] ANG_STEP [ANG_TABLE_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
    32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
  };

endpackage
`default_nettype wire

@@ src/snu_sqrt.sv @@
// Pipelined integer square root, one result bit per register stage.
// Depends on snu_pkg.
`default_nettype none
module snu_sqrt import snu_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [SQ_NW-1:0] radicand,
  output logic             out_valid,
  output logic [SQ_OW-1:0] root
);

  logic             vld [SQ_ITER+1];
  logic [SQ_NW-1:0] rem [SQ_ITER+1];
  logic [SQ_RW-1:0] acc [SQ_ITER+1];

  assign vld[0] = in_valid;
  assign rem[0] = radicand;
  assign acc[0] = '0;

  for (genvar j = 0; j < SQ_ITER; j++) begin : g_stage
    localparam int K = SQ_ITER - 1 - j;
    localparam logic [SQ_RW-1:0] BIT = SQ_RW'(1) << (2 * K);
    logic [SQ_RW-1:0] trial;
    logic             fits;

    assign trial = acc[j] + BIT;
    assign fits  = {1'b0, rem[j]} >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else begin
        vld[j+1] <= vld[j];
      end
      if (fits) begin
        rem[j+1] <= rem[j] - trial[SQ_NW-1:0];
        acc[j+1] <= (acc[j] >> 1) + BIT;
      end else begin
        rem[j+1] <= rem[j];
        acc[j+1] <= acc[j] >> 1;
      end
    end
  end

  assign out_valid = vld[SQ_ITER];
  assign root      = acc[SQ_ITER][SQ_OW-1:0];

endmodule
`default_nettype wire

@@ src/snu_cordic.sv @@
// Pipelined vectoring CORDIC that returns atan2(y, x) in units of 2^-32 turn.
// Depends on snu_pkg for the angle table and widths.
`default_nettype none
module snu_cordic import snu_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  logic  zero_neg,
  input  cvec_t x_in,
  input  cvec_t y_in,
  output logic  out_valid,
  output ang_t  angle
);

  logic  vld  [CORDIC_N+1];
  logic  spec [CORDIC_N+1];
  cvec_t xs   [CORDIC_N+1];
  cvec_t ys   [CORDIC_N+1];
  ang_t  acc  [CORDIC_N+1];

  // The axis cases are settled up front; their angle rides along frozen in the accumulator.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
    end
    xs[0]   <= x_in;
    ys[0]   <= y_in;
    spec[0] <= 1'b0;
    acc[0]  <= '0;
    if (y_in == '0) begin
      spec[0] <= 1'b1;
      if (x_in >= 0) acc[0] <= '0;
      else acc[0] <= zero_neg ? -ANG_HALF : ANG_HALF;
    end else if (x_in == '0) begin
      spec[0] <= 1'b1;
      acc[0]  <= (y_in > 0) ? ANG_QUARTER : -ANG_QUARTER;
    end else if (x_in < 0) begin
      if (y_in > 0) begin
        xs[0]  <= y_in;
        ys[0]  <= -x_in;
        acc[0] <= ANG_QUARTER;
      end else begin
        xs[0]  <= -y_in;
        ys[0]  <= x_in;
        acc[0] <= -ANG_QUARTER;
      end
    end
  end

  for (genvar i = 0; i < CORDIC_N; i++) begin : g_stage
    localparam ang_t STEP = AW'(ANG_STEP[i]);
    cvec_t dx, dy;
    assign dx = ys[i] >>> i;
    assign dy = xs[i] >>> i;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
      spec[i+1] <= spec[i];
      if (ys[i] > 0) begin
        xs[i+1]  <= xs[i] + dx;
        ys[i+1]  <= ys[i] - dy;
        acc[i+1] <= spec[i] ? acc[i] : acc[i] + STEP;
      end else begin
        xs[i+1]  <= xs[i] - dx;
        ys[i+1]  <= ys[i] + dy;
        acc[i+1] <= spec[i] ? acc[i] : acc[i] - STEP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vld[CORDIC_N];
    end
    angle <= acc[CORDIC_N];
  end

endmodule
`default_nettype wire

@@ src/sphere_normal_to_uv_top.sv @@
// Sphere normal to UV texture coordinates, top level.
// Depends on snu_pkg, snu_sqrt and snu_cordic.
//
// Usage: drive normal_x, normal_y, normal_z (signed Q1.14) and raise start for one
// cycle per beat. busy is always low, so a beat is taken on every cycle that start is high.
// Each beat returns one result beat: done is high for one cycle with u_coord and
// v_coord (unsigned Q0.16) valid in that same cycle.
// The result path runs through the input and radicand registers, the 31-stage square root
// that feeds acos, then the chain of 16 CORDIC stages with its entry and exit registers,
// and the output register.
// Throughput is one beat per clock; no beat waits on another.
// u = atan2(-z, x) mapped to [0, 1) of a turn, v = acos(-y) / pi with y clamped to [-1, 1].
// Reset clears every valid bit, so nothing in flight comes out after reset.
// The receiver cannot stall: results are presented once and are gone the next cycle.
`default_nettype none
module sphere_normal_to_uv_top import snu_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] normal_x,
  input  logic signed [15:0] normal_y,
  input  logic signed [15:0] normal_z,
  output logic               done,
  output logic        [15:0] u_coord,
  output logic        [15:0] v_coord
);

  assign busy = 1'b0;

  // Stage 0: capture, negate and clamp y.
  logic               v0;
  logic signed [15:0] x0, z0;
  logic signed [16:0] t0;
  logic signed [16:0] t_next;

  always_comb begin
    t_next = -{normal_y[15], normal_y};
    if (t_next > 17'sd16384) t_next = 17'sd16384;
    else if (t_next < -17'sd16384) t_next = -17'sd16384;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= start;
    end
    x0 <= normal_x;
    z0 <= normal_z;
    t0 <= t_next;
  end

  // Stage 1: radicand (1 - t^2) scaled for the root.
  logic               v1;
  logic signed [15:0] x1, z1;
  logic signed [16:0] t1;
  logic [SQ_NW-1:0]   rad;
  logic signed [33:0] tsq;

  assign tsq = t0 * t0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= v0;
    end
    x1  <= x0;
    z1  <= z0;
    t1  <= t0;
    rad <= {29'(34'sd268435456 - tsq), 32'b0};
  end

  logic             sq_valid;
  logic [SQ_OW-1:0] sq_root;

  snu_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v1),
    .radicand (rad),
    .out_valid(sq_valid),
    .root     (sq_root)
  );

  // Side data waits alongside the root.
  logic signed [15:0] xd [SQ_ITER];
  logic signed [15:0] zd [SQ_ITER];
  logic signed [16:0] td [SQ_ITER];

  always_ff @(posedge clk) begin
    xd[0] <= x1;
    zd[0] <= z1;
    td[0] <= t1;
  end

  for (genvar k = 1; k < SQ_ITER; k++) begin : g_delay
    always_ff @(posedge clk) begin
      xd[k] <= xd[k-1];
      zd[k] <= zd[k-1];
      td[k] <= td[k-1];
    end
  end

  cvec_t ux, uy, vx, vy;
  logic signed [16:0] negz;

  assign negz = -{zd[SQ_ITER-1][15], zd[SQ_ITER-1]};
  assign ux   = {{(DW-32){xd[SQ_ITER-1][15]}}, xd[SQ_ITER-1], 16'b0};
  assign uy   = {{(DW-33){negz[16]}}, negz, 16'b0};
  assign vx   = {{(DW-33){td[SQ_ITER-1][16]}}, td[SQ_ITER-1], 16'b0};
  assign vy   = {{(DW-SQ_OW){1'b0}}, sq_root};

  logic u_valid, v_valid;
  ang_t u_ang, v_ang;

  snu_cordic u_cordic_u (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sq_valid),
    .zero_neg (1'b1),
    .x_in     (ux),
    .y_in     (uy),
    .out_valid(u_valid),
    .angle    (u_ang)
  );

  snu_cordic u_cordic_v (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sq_valid),
    .zero_neg (1'b0),
    .x_in     (vx),
    .y_in     (vy),
    .out_valid(v_valid),
    .angle    (v_ang)
  );

  // Output stage: shift u to a half turn origin, clamp, round half up, saturate.
  logic signed [AW:0] ua;
  logic [32:0]        uc;
  logic [33:0]        ur;
  logic [31:0]        bc;
  logic [32:0]        vr;
  logic [15:0]        u_next, v_next;

  always_comb begin
    ua = {u_ang[AW-1], u_ang} + {ANG_HALF[AW-1], ANG_HALF};
    if (ua < 0) uc = '0;
    else if (ua > (AW+1)'(35'sh1_0000_0000)) uc = 33'h1_0000_0000;
    else uc = ua[32:0];
    ur = {1'b0, uc} + 34'd32768;
    u_next = (ur[33:16] > 18'd65535) ? 16'hFFFF : ur[31:16];

    if (v_ang < 0) bc = '0;
    else if (v_ang > ANG_HALF) bc = 32'h8000_0000;
    else bc = v_ang[31:0];
    vr = {1'b0, bc} + 33'd16384;
    v_next = (vr[32:15] > 18'd65535) ? 16'hFFFF : vr[30:15];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= u_valid & v_valid;
    end
    u_coord <= u_next;
    v_coord <= v_next;
  end

endmodule
`default_nettype wire

@@ src/snu_checker.sv @@
// Port-level checks for the sphere normal to UV block, bound to the top level.
// Depends on snu_pkg for the pipeline latency.
`default_nettype none
module snu_checker import snu_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic signed [15:0] normal_y,
  input logic               done,
  input logic        [15:0] v_coord
);

  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  a_beat_returns: assert property (@(posedge clk) disable iff (rst)
    start |-> ##PIPE_LAT done)
    else $error("result beat missing");

  a_pole_up: assert property (@(posedge clk) disable iff (rst)
    (start && normal_y == 16'sd16384) |-> ##PIPE_LAT (v_coord == 16'hFFFF))
    else $error("v at upper pole wrong");

  a_pole_down: assert property (@(posedge clk) disable iff (rst)
    (start && normal_y == -16'sd16384) |-> ##PIPE_LAT (v_coord == 16'h0000))
    else $error("v at lower pole wrong");

endmodule

bind sphere_normal_to_uv_top snu_checker u_snu_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .normal_y(normal_y),
  .done    (done),
  .v_coord (v_coord)
);
`default_nettype wire
